// File: sv/y2r_pkg.sv
// ----------------------------------------------------------------------------
// y2r_pkg: shared constants and types for the YUYV to RGB converter
// Coefficient values in Q1.16, chroma bias, channel limits and the
// per-macropixel term bundle passed from the input stage to the channels.
// ----------------------------------------------------------------------------
`default_nettype none

package y2r_pkg;

   localparam int PixW  = 8;
   localparam int FracW = 16;
   localparam int SumW  = 27;   // signed Q10.16 sum, sign bit included
   localparam int IntW  = SumW - 1 - FracW;

   localparam logic signed [17:0] COEF_RV = 18'sd89831;
   localparam logic signed [17:0] COEF_GV = 18'sd45744;
   localparam logic signed [17:0] COEF_GU = 18'sd22127;
   localparam logic signed [17:0] COEF_BU = 18'sd113538;

   localparam logic signed [PixW:0] CHROMA_BIAS = 9'sd128;
   localparam logic [PixW-1:0]      CH_MAX      = 8'd255;
   localparam logic [PixW-1:0]      SCALE_NUM   = 8'd220;
   localparam logic [PixW-1:0]      OUT_MAX     = 8'd219;

   typedef struct packed {
      logic [PixW-1:0]        luma_first;
      logic [PixW-1:0]        luma_second;
      logic signed [SumW-1:0] red_term;
      logic signed [SumW-1:0] green_term;
      logic signed [SumW-1:0] blue_term;
   } pix_terms_type;

endpackage

`default_nettype wire

// File: sv/y2r_input_stage.sv
// ----------------------------------------------------------------------------
// y2r_input_stage: input register of the converter
// Forms the chroma products of one macropixel and registers them together
// with both luma samples; drives the input-side stall.
// ----------------------------------------------------------------------------
`default_nettype none

module y2r_input_stage (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [y2r_pkg::PixW-1:0]      req_luma_first,
   input  wire logic [y2r_pkg::PixW-1:0]      req_chroma_blue,
   input  wire logic [y2r_pkg::PixW-1:0]      req_luma_second,
   input  wire logic [y2r_pkg::PixW-1:0]      req_chroma_red,
   input  wire logic                          advance,
   output logic                               terms_valid,
   output y2r_pkg::pix_terms_type             terms
);

   logic                             valid_ff;
   logic                             valid_in;
   y2r_pkg::pix_terms_type           terms_ff;
   y2r_pkg::pix_terms_type           terms_in;
   logic signed [y2r_pkg::PixW:0]    du;
   logic signed [y2r_pkg::PixW:0]    dv;
   logic                             load;

   // hold while a transaction waits here and the result side cannot take it
   assign req_stall = valid_ff && !advance;
   assign load      = req_valid && !req_stall;

   always_comb begin
      du = $signed({1'b0, req_chroma_blue}) - y2r_pkg::CHROMA_BIAS;
      dv = $signed({1'b0, req_chroma_red}) - y2r_pkg::CHROMA_BIAS;
      terms_in.luma_first  = req_luma_first;
      terms_in.luma_second = req_luma_second;
      terms_in.red_term    = y2r_pkg::SumW'(dv) * y2r_pkg::SumW'(y2r_pkg::COEF_RV);
      terms_in.green_term  = -(y2r_pkg::SumW'(dv) * y2r_pkg::SumW'(y2r_pkg::COEF_GV))
                             - (y2r_pkg::SumW'(du) * y2r_pkg::SumW'(y2r_pkg::COEF_GU));
      terms_in.blue_term   = y2r_pkg::SumW'(du) * y2r_pkg::SumW'(y2r_pkg::COEF_BU);
   end

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         terms_ff <= terms_in;
      end
   end

   assign terms_valid = valid_ff;
   assign terms       = terms_ff;

endmodule

`default_nettype wire

// File: sv/y2r_channel.sv
// ----------------------------------------------------------------------------
// y2r_channel: one colour channel
// Adds luma to the chroma term, truncates toward zero, clamps to 0..255 and
// scales by 220/256 with floor.
// ----------------------------------------------------------------------------
`default_nettype none

module y2r_channel (
   input  wire logic [y2r_pkg::PixW-1:0]        luma,
   input  wire logic signed [y2r_pkg::SumW-1:0] term,
   output logic [y2r_pkg::PixW-1:0]             level
);

   logic signed [y2r_pkg::SumW-1:0] sum;
   logic [y2r_pkg::IntW-1:0]        whole;
   logic [y2r_pkg::PixW-1:0]        clamped;
   logic [2*y2r_pkg::PixW-1:0]      scaled;

   always_comb begin
      sum   = $signed({{(y2r_pkg::SumW - y2r_pkg::PixW - y2r_pkg::FracW){1'b0}},
                       luma, {y2r_pkg::FracW{1'b0}}}) + term;
      whole = sum[y2r_pkg::SumW-2:y2r_pkg::FracW];
      // any negative sum, even one above -1, ends at zero
      if (sum[y2r_pkg::SumW-1]) begin
         clamped = '0;
      end else if (whole > y2r_pkg::IntW'(y2r_pkg::CH_MAX)) begin
         clamped = y2r_pkg::CH_MAX;
      end else begin
         clamped = whole[y2r_pkg::PixW-1:0];
      end
      scaled = (2*y2r_pkg::PixW)'(clamped) * (2*y2r_pkg::PixW)'(y2r_pkg::SCALE_NUM);
      level  = scaled[2*y2r_pkg::PixW-1:y2r_pkg::PixW];
   end

endmodule

`default_nettype wire

// File: sv/yuyv_to_rgb_converter.sv
// Path: an accepted macropixel passes the input register, then the result register, to rsp_*.
// Throughput: one macropixel per cycle, sustained, when rsp_stall stays low.
// Two register stages set this: the input register (chroma products) and the
// result register (sum, clamp and scale); a stalled result holds both in turn.
// Reset clears both valid flags; no payload is cleared.
// ----------------------------------------------------------------------------
// yuyv_to_rgb_converter: YUYV 4:2:2 macropixel to two RGB pixels
// Converts each packed macropixel into two clamped, 220/256-scaled RGB
// pixels.
// ----------------------------------------------------------------------------
`default_nettype none

module yuyv_to_rgb_converter (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [y2r_pkg::PixW-1:0] req_luma_first,
   input  wire logic [y2r_pkg::PixW-1:0] req_chroma_blue,
   input  wire logic [y2r_pkg::PixW-1:0] req_luma_second,
   input  wire logic [y2r_pkg::PixW-1:0] req_chroma_red,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [y2r_pkg::PixW-1:0]      rsp_red_first,
   output logic [y2r_pkg::PixW-1:0]      rsp_green_first,
   output logic [y2r_pkg::PixW-1:0]      rsp_blue_first,
   output logic [y2r_pkg::PixW-1:0]      rsp_red_second,
   output logic [y2r_pkg::PixW-1:0]      rsp_green_second,
   output logic [y2r_pkg::PixW-1:0]      rsp_blue_second
);

   logic                         terms_valid;
   y2r_pkg::pix_terms_type       terms;
   logic                         advance;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic [y2r_pkg::PixW-1:0]     level [6];
   logic [y2r_pkg::PixW-1:0]     level_ff [6];

   // result register free, or being emptied this cycle
   assign advance = !rsp_valid_ff || !rsp_stall;

   y2r_input_stage u_input (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_luma_first  (req_luma_first),
      .req_chroma_blue (req_chroma_blue),
      .req_luma_second (req_luma_second),
      .req_chroma_red  (req_chroma_red),
      .advance         (advance),
      .terms_valid     (terms_valid),
      .terms           (terms)
   );

   y2r_channel u_red_first    (.luma(terms.luma_first),  .term(terms.red_term),
                               .level(level[0]));
   y2r_channel u_green_first  (.luma(terms.luma_first),  .term(terms.green_term),
                               .level(level[1]));
   y2r_channel u_blue_first   (.luma(terms.luma_first),  .term(terms.blue_term),
                               .level(level[2]));
   y2r_channel u_red_second   (.luma(terms.luma_second), .term(terms.red_term),
                               .level(level[3]));
   y2r_channel u_green_second (.luma(terms.luma_second), .term(terms.green_term),
                               .level(level[4]));
   y2r_channel u_blue_second  (.luma(terms.luma_second), .term(terms.blue_term),
                               .level(level[5]));

   always_comb begin
      if (advance) begin
         rsp_valid_in = terms_valid;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && terms_valid) begin
         level_ff <= level;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_red_first    = level_ff[0];
   assign rsp_green_first  = level_ff[1];
   assign rsp_blue_first   = level_ff[2];
   assign rsp_red_second   = level_ff[3];
   assign rsp_green_second = level_ff[4];
   assign rsp_blue_second  = level_ff[5];

   // stall only with a transaction waiting in the input register
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (terms_valid && rsp_valid_ff && rsp_stall))
      else $error("input stalled without a blocked transaction");

   // a waiting transaction moves into a free result register next cycle
   assert property (@(posedge clock) disable iff (reset)
      (terms_valid && advance) |=> rsp_valid_ff)
      else $error("transaction lost between stages");

   // scaled channels never exceed the 220/256 ceiling
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_red_first <= y2r_pkg::OUT_MAX
                        && rsp_green_first <= y2r_pkg::OUT_MAX
                        && rsp_blue_first <= y2r_pkg::OUT_MAX
                        && rsp_red_second <= y2r_pkg::OUT_MAX
                        && rsp_green_second <= y2r_pkg::OUT_MAX
                        && rsp_blue_second <= y2r_pkg::OUT_MAX))
      else $error("channel above scaled range");

   // no valid flag survives reset
   assert property (@(posedge clock)
      $past(reset) |-> (!rsp_valid_ff && !terms_valid))
      else $error("valid flag set after reset");

endmodule

`default_nettype wire
